### design/pbsu_pkg.sv
package pbsu_pkg;

   localparam int FUNC_W        = 2;
   localparam int PROC_ID_W     = 4;
   localparam int KIND_W        = 2;
   localparam int INDEX_W       = 4;
   localparam int COUNT_W       = 5;
   localparam int NUM_PROCS_W   = 5;
   localparam int NUM_PHASES_W  = 4;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 5;

   // largest processor count and phase count the field widths can carry
   localparam int PROC_LIMIT    = 2 ** PROC_ID_W;
   localparam int PHASE_LIMIT   = 2 ** NUM_PHASES_W - 1;

   localparam int NUM_PROCS_RST  = 16;
   localparam int NUM_PHASES_RST = 8;
   localparam int MIN_PHASES     = 3;

   localparam logic [FUNC_W-1:0] FUNC_STRONG = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_WEAK   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CHECK  = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

   localparam logic [KIND_W-1:0] KIND_WEAK     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RELEASE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CHECK    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_OVERFLOW = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_PROCS  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_PHASES = 1'd1;

   typedef struct packed {
      logic [FUNC_W-1:0]    func;
      logic [PROC_ID_W-1:0] proc_id;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic [PROC_ID_W-1:0] dest_proc;
      logic [INDEX_W-1:0]   arrival_index;
      logic [COUNT_W-1:0]   count;
      logic                 last;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_STRONG,
      OP_WEAK,
      OP_CHECK
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [PROC_ID_W-1:0] pid;
   } cmd_type;

   // effective (saturated) configuration
   typedef struct packed {
      logic [NUM_PROCS_W-1:0]  np;
      logic [NUM_PHASES_W-1:0] nph;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_EMIT,
      ST_CLEAR
   } back_state_type;

endpackage

### design/pbsu_ram.sv
module pbsu_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### design/pbsu_fifo.sv
module pbsu_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

### design/pbsu_front.sv
module pbsu_front #(
   parameter int MAX_PROCS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pbsu_pkg::req_type req_data,
   output logic              full,
   input  logic              cmd_pop,
   output logic              cmd_valid,
   output pbsu_pkg::cmd_type cmd
);

   localparam int CMD_W = $bits(pbsu_pkg::cmd_type);

   logic [pbsu_pkg::PROC_ID_W-1:0] pid_mod [pbsu_pkg::PROC_LIMIT];
   pbsu_pkg::cmd_type              cmd_new;
   logic                           cmd_push;
   logic                           cmd_empty;
   logic [CMD_W-1:0]               cmd_bits;

   // processor id folded modulo MAX_PROCS into the supported processor range
   for (genvar g = 0; g < pbsu_pkg::PROC_LIMIT; g++) begin : g_pid
      assign pid_mod[g] = pbsu_pkg::PROC_ID_W'(g % MAX_PROCS);
   end

   always_comb begin
      cmd_new.pid = pid_mod[req_data.proc_id];
      case (req_data.func)
         pbsu_pkg::FUNC_STRONG: cmd_new.op = pbsu_pkg::OP_STRONG;
         pbsu_pkg::FUNC_WEAK:   cmd_new.op = pbsu_pkg::OP_WEAK;
         default:               cmd_new.op = pbsu_pkg::OP_CHECK;
      endcase
   end

   // unknown function code is dropped here and never reaches the back end
   assign cmd_push = push && !full && (req_data.func != pbsu_pkg::FUNC_NONE);

   pbsu_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (2)
   ) u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd_new),
      .full  (full),
      .pop   (cmd_pop),
      .rdata (cmd_bits),
      .empty (cmd_empty)
   );

   assign cmd_valid = !cmd_empty;
   assign cmd       = pbsu_pkg::cmd_type'(cmd_bits);

endmodule

### design/pbsu_back.sv
module pbsu_back #(
   parameter int MAX_PROCS  = 16,
   parameter int MAX_PHASES = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  pbsu_pkg::cfg_type cfg,
   input  logic              cmd_valid,
   input  pbsu_pkg::cmd_type cmd,
   output logic              cmd_pop,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output pbsu_pkg::rsp_type rsp_data
);

   localparam int PR_DEPTH = (MAX_PROCS < pbsu_pkg::PROC_LIMIT) ? MAX_PROCS
                                                                 : pbsu_pkg::PROC_LIMIT;
   localparam int PH_DEPTH = (MAX_PHASES < pbsu_pkg::PHASE_LIMIT) ? MAX_PHASES
                                                                   : pbsu_pkg::PHASE_LIMIT;
   localparam int PIW      = (PR_DEPTH > 1) ? $clog2(PR_DEPTH) : 1;
   localparam int PHW      = $clog2(PH_DEPTH);
   localparam int AW       = $clog2(PH_DEPTH * PR_DEPTH);
   localparam int RSP_W    = $bits(pbsu_pkg::rsp_type);
   localparam int LSP_RST  = ((pbsu_pkg::NUM_PHASES_RST < PH_DEPTH) ?
                              pbsu_pkg::NUM_PHASES_RST : PH_DEPTH) - 1;
   localparam int CW       = pbsu_pkg::COUNT_W;
   localparam int NW       = pbsu_pkg::NUM_PHASES_W;

   pbsu_pkg::back_state_type state_ff, state_in;

   pbsu_pkg::cmd_type        cmd_ff, cmd_in;
   logic [PHW-1:0]           which_ff, which_in;
   logic [pbsu_pkg::INDEX_W-1:0] k_ff, k_in;
   logic [PHW-1:0]           clr_ff, clr_in;
   logic [PHW-1:0]           lsp_ff, lsp_in;
   logic [PHW-1:0]           proc_phase_ff [PR_DEPTH];
   logic [PHW-1:0]           proc_phase_in [PR_DEPTH];
   logic [CW-1:0]            counter_ff [PH_DEPTH];
   logic [CW-1:0]            counter_in [PH_DEPTH];

   logic [PIW-1:0]           pid_idx;
   logic [PHW-1:0]           which_raw, which, which_next, clr_next;
   logic [CW-1:0]            idx, idx_plus;
   logic                     is_check, is_ovf, is_arrive, is_weak, is_fill, emits;
   logic                     go, rel_last;

   logic                     ram_we;
   logic [AW-1:0]            ram_waddr, ram_raddr;
   logic [pbsu_pkg::PROC_ID_W-1:0] ram_rdata;

   logic                     out_push, out_full;
   pbsu_pkg::rsp_type        out_data;
   logic [RSP_W-1:0]         out_bits;

   // decode of the command under execution
   assign pid_idx    = cmd_ff.pid[PIW-1:0];
   assign which_raw  = proc_phase_ff[pid_idx];
   // stale phase from an earlier, larger phase count reads as phase zero
   assign which      = (NW'(which_raw) >= cfg.nph) ? '0 : which_raw;
   assign idx        = counter_ff[which];
   assign idx_plus   = idx + CW'(1);
   assign is_check   = (cmd_ff.op == pbsu_pkg::OP_CHECK);
   assign is_ovf     = !is_check && (idx >= cfg.np);
   assign is_arrive  = !is_check && !is_ovf;
   assign is_weak    = (cmd_ff.op == pbsu_pkg::OP_WEAK);
   assign is_fill    = is_arrive && (cmd_ff.op == pbsu_pkg::OP_STRONG) && (idx_plus == cfg.np);
   assign emits      = is_check || is_ovf || (is_arrive && is_weak);
   assign go         = !emits || !out_full;
   assign which_next = (NW'(which) + NW'(1) == cfg.nph) ? '0 : which + PHW'(1);
   assign clr_next   = (NW'(clr_ff) + NW'(1) == cfg.nph) ? '0 : clr_ff + PHW'(1);
   assign rel_last   = (CW'(k_ff) + CW'(1) == cfg.np);

   assign ram_waddr  = AW'(which) * AW'(PR_DEPTH) + AW'(idx);
   assign ram_raddr  = AW'(which_ff) * AW'(PR_DEPTH) + AW'(k_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pbsu_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               state_in = pbsu_pkg::ST_EXEC;
            end
         end
         pbsu_pkg::ST_EXEC: begin
            if (go) begin
               state_in = is_fill ? pbsu_pkg::ST_READ : pbsu_pkg::ST_IDLE;
            end
         end
         pbsu_pkg::ST_READ: begin
            state_in = pbsu_pkg::ST_EMIT;
         end
         pbsu_pkg::ST_EMIT: begin
            if (!out_full) begin
               state_in = rel_last ? pbsu_pkg::ST_CLEAR : pbsu_pkg::ST_READ;
            end
         end
         pbsu_pkg::ST_CLEAR: begin
            if (clr_ff == which_ff) begin
               state_in = pbsu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pbsu_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd_pop       = 1'b0;
      cmd_in        = cmd_ff;
      which_in      = which_ff;
      k_in          = k_ff;
      clr_in        = clr_ff;
      lsp_in        = lsp_ff;
      proc_phase_in = proc_phase_ff;
      counter_in    = counter_ff;
      ram_we        = 1'b0;
      out_push      = 1'b0;
      out_data      = '0;
      case (state_ff)
         pbsu_pkg::ST_IDLE: begin
            cmd_pop = cmd_valid;
            cmd_in  = cmd;
         end
         pbsu_pkg::ST_EXEC: begin
            out_data.dest_proc = cmd_ff.pid;
            out_data.last      = 1'b1;
            if (is_check) begin
               out_data.kind  = pbsu_pkg::KIND_CHECK;
               out_data.count = idx;
            end else if (is_ovf) begin
               out_data.kind  = pbsu_pkg::KIND_OVERFLOW;
               out_data.count = idx;
            end else begin
               out_data.kind          = pbsu_pkg::KIND_WEAK;
               out_data.arrival_index = idx[pbsu_pkg::INDEX_W-1:0];
               out_data.count         = idx_plus;
            end
            if (go) begin
               out_push = emits;
               if (is_arrive) begin
                  ram_we                 = 1'b1;
                  counter_in[which]      = idx_plus;
                  proc_phase_in[pid_idx] = which_next;
               end
               which_in = which;
               k_in     = '0;
               // sweep starts at the last strong phase, saturated into range
               clr_in   = (NW'(lsp_ff) >= cfg.nph) ? PHW'(cfg.nph - NW'(1)) : lsp_ff;
            end
         end
         pbsu_pkg::ST_READ: begin
         end
         pbsu_pkg::ST_EMIT: begin
            out_data.kind          = pbsu_pkg::KIND_RELEASE;
            out_data.dest_proc     = ram_rdata;
            out_data.arrival_index = k_ff;
            out_data.count         = cfg.np;
            out_data.last          = rel_last;
            out_push               = !out_full;
            if (!out_full) begin
               k_in = k_ff + pbsu_pkg::INDEX_W'(1);
            end
         end
         pbsu_pkg::ST_CLEAR: begin
            if (clr_ff != which_ff) begin
               counter_in[clr_ff] = '0;
               clr_in             = clr_next;
            end else begin
               lsp_in = which_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pbsu_pkg::ST_IDLE;
         lsp_ff   <= PHW'(LSP_RST);
         for (int i = 0; i < PR_DEPTH; i++) begin
            proc_phase_ff[i] <= '0;
         end
         for (int i = 0; i < PH_DEPTH; i++) begin
            counter_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         lsp_ff        <= lsp_in;
         proc_phase_ff <= proc_phase_in;
         counter_ff    <= counter_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      which_ff <= which_in;
      k_ff     <= k_in;
      clr_ff   <= clr_in;
   end

   pbsu_ram #(
      .WIDTH (pbsu_pkg::PROC_ID_W),
      .DEPTH (PH_DEPTH * PR_DEPTH)
   ) u_arrival_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (cmd_ff.pid),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   pbsu_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (2)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_data),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (out_bits),
      .empty (rsp_empty)
   );

   assign rsp_data = pbsu_pkg::rsp_type'(out_bits);

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result beat pushed into a full queue");

   a_release_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pbsu_pkg::ST_EMIT) |-> (CW'(k_ff) < cfg.np))
      else $error("release index past the fill level");

   a_released_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pbsu_pkg::ST_READ) |-> (counter_ff[which_ff] == cfg.np))
      else $error("releasing a phase that is not full");

   a_clear_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pbsu_pkg::ST_CLEAR) |-> (NW'(clr_ff) < cfg.nph))
      else $error("clear sweep index out of phase range");

endmodule

### design/phased_barrier_sync_unit.sv
// channel   direction  handshake                       payload
// request   in         push / full                     req_data  (func, proc_id)
// response  out        empty / pop                     rsp_data  (kind, dest_proc,
//                                                                 arrival_index, count, last)
// csr       in         csr_we, csr_index               csr_wdata (num_procs, num_phases)
//
// a check, weak or non-filling strong arrival goes through the idle and exec states of
// the execute fsm; a filling strong arrival then goes through read (arrival ram read)
// and emit (result beat) for each released processor, then through clear, which
// resets the phase counters from the last released phase up to, not including, this one
// two-entry queues on both sides let requests and result pops stall independently
// synchronous reset clears phase counters and processor phases at once, no sweep
module phased_barrier_sync_unit #(
   parameter int MAX_PROCS  = 16,
   parameter int MAX_PHASES = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  pbsu_pkg::req_type                    req_data,
   output logic                                 empty,
   input  logic                                 pop,
   output pbsu_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [pbsu_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pbsu_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int PR_DEPTH = (MAX_PROCS < pbsu_pkg::PROC_LIMIT) ? MAX_PROCS
                                                                 : pbsu_pkg::PROC_LIMIT;
   localparam int PH_DEPTH = (MAX_PHASES < pbsu_pkg::PHASE_LIMIT) ? MAX_PHASES
                                                                   : pbsu_pkg::PHASE_LIMIT;
   localparam int PW = pbsu_pkg::NUM_PROCS_W;
   localparam int HW = pbsu_pkg::NUM_PHASES_W;

   logic [PW-1:0]     num_procs_ff, num_procs_in;
   logic [HW-1:0]     num_phases_ff, num_phases_in;
   pbsu_pkg::cfg_type cfg;
   logic              cmd_valid, cmd_pop;
   pbsu_pkg::cmd_type cmd;

   always_comb begin
      num_procs_in  = num_procs_ff;
      num_phases_in = num_phases_ff;
      if (csr_we) begin
         case (csr_index)
            pbsu_pkg::CSR_NUM_PROCS:  num_procs_in  = csr_wdata;
            pbsu_pkg::CSR_NUM_PHASES: num_phases_in = csr_wdata[HW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_procs_ff  <= PW'(pbsu_pkg::NUM_PROCS_RST);
         num_phases_ff <= HW'(pbsu_pkg::NUM_PHASES_RST);
      end else begin
         num_procs_ff  <= num_procs_in;
         num_phases_ff <= num_phases_in;
      end
   end

   // saturate registers into the supported ranges
   always_comb begin
      if (num_procs_ff == '0) begin
         cfg.np = PW'(1);
      end else if (num_procs_ff > PW'(PR_DEPTH)) begin
         cfg.np = PW'(PR_DEPTH);
      end else begin
         cfg.np = num_procs_ff;
      end
      if (num_phases_ff < HW'(pbsu_pkg::MIN_PHASES)) begin
         cfg.nph = HW'(pbsu_pkg::MIN_PHASES);
      end else if (num_phases_ff > HW'(PH_DEPTH)) begin
         cfg.nph = HW'(PH_DEPTH);
      end else begin
         cfg.nph = num_phases_ff;
      end
   end

   pbsu_front #(
      .MAX_PROCS (MAX_PROCS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_data  (req_data),
      .full      (full),
      .cmd_pop   (cmd_pop),
      .cmd_valid (cmd_valid),
      .cmd       (cmd)
   );

   pbsu_back #(
      .MAX_PROCS  (MAX_PROCS),
      .MAX_PHASES (MAX_PHASES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_pop   (pop),
      .rsp_empty (empty),
      .rsp_data  (rsp_data)
   );

endmodule
